>>> design/eul_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package eul_pkg;

	localparam int ANGLE_W = 16;
	localparam int ENTRY_W = 16;
	localparam int TRIG_W  = 32;

	// angle constants in Q28
	localparam logic signed [33:0] HALF_PI_Q28    = 34'sd421657428;
	localparam logic signed [33:0] QUARTER_PI_Q28 = 34'sd210828714;
	localparam logic signed [31:0] Q30_ONE        = 32'sd1073741824;

	localparam int SC_LAT  = 21;
	localparam int MAT_LAT = 6;
	localparam int LAT     = SC_LAT + MAT_LAT;

	localparam logic signed [63:0] Q14_MAX = 64'sd16384;
	localparam logic signed [63:0] Q14_MIN = -64'sd16384;

	// round to nearest, halves away from zero
	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] p,
		input int unsigned sh);
		logic signed [63:0] half;
		logic signed [63:0] t;
		half = 64'sd1 <<< (sh - 1);
		t = p + half - $signed({63'd0, p[63]});
		return t >>> sh;
	endfunction

	// Q30 sum to saturated Q1.14
	function automatic logic [ENTRY_W-1:0] to_q14(input logic signed [32:0] v);
		logic signed [63:0] e;
		e = rnd_shift(64'(v), 16);
		if (e > Q14_MAX) begin
			e = Q14_MAX;
		end
		if (e < Q14_MIN) begin
			e = Q14_MIN;
		end
		return e[ENTRY_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> design/eul_sincos.sv
`timescale 1ns / 1ps
`default_nettype none

module eul_sincos (
	input  wire logic                               clk,
	input  wire logic                               en,
	input  wire logic signed [eul_pkg::ANGLE_W-1:0] angle,
	output logic signed [eul_pkg::TRIG_W-1:0]       sin_val,
	output logic signed [eul_pkg::TRIG_W-1:0]       cos_val
);

	logic signed [33:0] x_w;
	logic signed [33:0] off_w;
	logic [1:0]         q_w;

	logic signed [33:0] x_s1;
	logic signed [33:0] off_s1;
	logic signed [31:0] r_s2;
	logic signed [63:0] rr_s3;
	logic signed [31:0] r2_s4;

	logic [1:0]         q_ln  [1:20];
	logic signed [31:0] r_ln  [3:17];
	logic signed [31:0] r2_ln [4:17];

	logic signed [31:0] n_w [2][4];

	logic signed [31:0] sin_s20;
	logic signed [31:0] cos_s20;
	logic signed [31:0] sin_s21;
	logic signed [31:0] cos_s21;

	// quadrant search: pick j with x in [j*pi/2 - pi/4, j*pi/2 + pi/4)
	always_comb begin
		x_w   = 34'(angle) <<< 16;
		off_w = -34'sd5 * eul_pkg::HALF_PI_Q28;
		q_w   = 2'd3;
		for (int j = -4; j <= 5; j++) begin
			if (x_w >= 34'(j) * eul_pkg::HALF_PI_Q28 - eul_pkg::QUARTER_PI_Q28) begin
				off_w = 34'(j) * eul_pkg::HALF_PI_Q28;
				q_w   = 2'(j);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x_w;
			off_s1 <= off_w;
			r_s2   <= 32'((x_s1 - off_s1) <<< 2);
			rr_s3  <= r_s2 * r_s2;
			r2_s4  <= 32'(eul_pkg::rnd_shift(rr_s3, 30));
			q_ln[1] <= q_w;
			for (int k = 2; k <= 20; k++) begin
				q_ln[k] <= q_ln[k-1];
			end
			r_ln[3] <= r_s2;
			for (int k = 4; k <= 17; k++) begin
				r_ln[k] <= r_ln[k-1];
			end
			r2_ln[4] <= 32'(eul_pkg::rnd_shift(rr_s3, 30));
			for (int k = 5; k <= 17; k++) begin
				r2_ln[k] <= r2_ln[k-1];
			end
		end
	end

	assign n_w[0][0] = r2_s4;
	assign n_w[1][0] = r2_s4;

	// Horner rounds: u = 1 - n/D, then n = round(m * u); lane 0 sine, lane 1 cosine
	for (genvar l = 0; l < 2; l++) begin : g_lane
		for (genvar i = 0; i < 3; i++) begin : g_round
			localparam int D = (l == 0) ? ((i == 0) ? 42 : (i == 1) ? 20 : 6)
				: ((i == 0) ? 56 : (i == 1) ? 30 : 12);
			localparam logic [31:0] MAG = 32'((64'd1 << 32) / D);

			logic [61:0]        prod_s1;
			logic [29:0]        n_s1;
			logic [29:0]        q0_s2;
			logic [29:0]        rem_s2;
			logic [30:0]        u_s3;
			logic signed [63:0] p_s4;
			logic signed [31:0] n_s5;
			logic signed [31:0] opnd;

			assign opnd = (l == 0 && i == 2) ? r_ln[17] : r2_ln[7 + 5 * i];

			always_ff @(posedge clk) begin
				if (en) begin
					prod_s1 <= 62'(n_w[l][i][29:0]) * 62'(MAG);
					n_s1    <= n_w[l][i][29:0];
					q0_s2   <= 30'(prod_s1 >> 32);
					rem_s2  <= n_s1 - 30'(30'(prod_s1 >> 32) * 30'(D));
					// reciprocal estimate is low by at most one
					u_s3    <= 31'(eul_pkg::Q30_ONE) - 31'(q0_s2)
						- 31'(rem_s2 >= 30'(D));
					p_s4    <= opnd * $signed({33'd0, u_s3});
					n_s5    <= 32'(eul_pkg::rnd_shift(p_s4, 30));
				end
			end

			assign n_w[l][i+1] = n_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_s20 <= n_w[0][3];
			cos_s20 <= eul_pkg::Q30_ONE - (n_w[1][3] >>> 1);
			unique case (q_ln[20])
				2'd0: begin
					sin_s21 <= sin_s20;
					cos_s21 <= cos_s20;
				end
				2'd1: begin
					sin_s21 <= cos_s20;
					cos_s21 <= -sin_s20;
				end
				2'd2: begin
					sin_s21 <= -sin_s20;
					cos_s21 <= -cos_s20;
				end
				default: begin
					sin_s21 <= -cos_s20;
					cos_s21 <= sin_s20;
				end
			endcase
		end
	end

	assign sin_val = sin_s21;
	assign cos_val = cos_s21;

endmodule

`default_nettype wire

>>> design/euler_to_rotation_matrix_top.sv
// Throughput: one beat per cycle while the output is not held; sine/cosine (21 stages)
// and matrix (6 stages) are fully pipelined, a 32x32 multiplier with its rounding split
// over two stages.
// A stall on the output freezes every stage, so nothing is lost or repeated.
// Reset (arst_n low, asynchronous) clears the valid bits only; data regs hold junk.
`timescale 1ns / 1ps
`default_nettype none

module euler_to_rotation_matrix_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [47:0]  s_tdata,  // roll_angle[15:0], pitch_angle[31:16], yaw_angle[47:32]
	input  wire logic [0:0]   s_tuser,  // rotation_order[0]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [143:0]      m_tdata   // m11, m12, m13, m21, m22, m23, m31, m32, m33; 16 bits each
);

	localparam int LAT = eul_pkg::LAT;

	logic en;
	logic vld_s [1:LAT];
	logic ord_s [1:LAT-1];

	logic signed [31:0] sph, cph, sth, cth, sps, cps;

	// stage 22: first products
	logic signed [63:0] ss_s22, cs_s22, p0_s22, p3_s22, p7_s22, p8_s22;
	logic signed [63:0] p1_s22, p2_s22, p4_s22, p5_s22;
	logic signed [31:0] sps_s22, cps_s22, sth_s22;
	// stage 23: rounded
	logic signed [31:0] ss_s23, cs_s23, p0_s23, p3_s23, p7_s23, p8_s23;
	logic signed [31:0] p1_s23, p2_s23, p4_s23, p5_s23;
	logic signed [31:0] sps_s23, cps_s23, sth_s23;
	// stage 24: triple products
	logic signed [63:0] t1_s24, t2_s24, t3_s24, t4_s24;
	logic signed [31:0] p0_s24, p3_s24, p7_s24, p8_s24, p1_s24, p2_s24, p4_s24, p5_s24;
	logic signed [31:0] sth_s24;
	// stage 25
	logic signed [31:0] t1_s25, t2_s25, t3_s25, t4_s25;
	logic signed [31:0] p0_s25, p3_s25, p7_s25, p8_s25, p1_s25, p2_s25, p4_s25, p5_s25;
	logic signed [31:0] sth_s25;
	// stage 26: 3-2-1 matrix, row-major, Q30
	logic signed [32:0] m_s26 [9];
	// stage 27: output register
	logic [15:0] out_s27 [9];

	// advance the whole pipe unless the output beat is held
	assign en       = !vld_s[LAT] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= s_tvalid;
			for (int k = 2; k <= LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ord_s[1] <= s_tuser[0];
			for (int k = 2; k <= LAT - 1; k++) begin
				ord_s[k] <= ord_s[k-1];
			end
		end
	end

	eul_sincos u_roll (
		.clk     (clk),
		.en      (en),
		.angle   ($signed(s_tdata[15:0])),
		.sin_val (sph),
		.cos_val (cph)
	);

	eul_sincos u_pitch (
		.clk     (clk),
		.en      (en),
		.angle   ($signed(s_tdata[31:16])),
		.sin_val (sth),
		.cos_val (cth)
	);

	eul_sincos u_yaw (
		.clk     (clk),
		.en      (en),
		.angle   ($signed(s_tdata[47:32])),
		.sin_val (sps),
		.cos_val (cps)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			// products of two trig terms
			ss_s22  <= sph * sth;
			cs_s22  <= cph * sth;
			p0_s22  <= cth * cps;
			p3_s22  <= cth * sps;
			p7_s22  <= sph * cth;
			p8_s22  <= cph * cth;
			p1_s22  <= cph * sps;
			p2_s22  <= sph * sps;
			p4_s22  <= cph * cps;
			p5_s22  <= sph * cps;
			sps_s22 <= sps;
			cps_s22 <= cps;
			sth_s22 <= sth;

			// round back to Q30
			ss_s23  <= 32'(eul_pkg::rnd_shift(ss_s22, 30));
			cs_s23  <= 32'(eul_pkg::rnd_shift(cs_s22, 30));
			p0_s23  <= 32'(eul_pkg::rnd_shift(p0_s22, 30));
			p3_s23  <= 32'(eul_pkg::rnd_shift(p3_s22, 30));
			p7_s23  <= 32'(eul_pkg::rnd_shift(p7_s22, 30));
			p8_s23  <= 32'(eul_pkg::rnd_shift(p8_s22, 30));
			p1_s23  <= 32'(eul_pkg::rnd_shift(p1_s22, 30));
			p2_s23  <= 32'(eul_pkg::rnd_shift(p2_s22, 30));
			p4_s23  <= 32'(eul_pkg::rnd_shift(p4_s22, 30));
			p5_s23  <= 32'(eul_pkg::rnd_shift(p5_s22, 30));
			sps_s23 <= sps_s22;
			cps_s23 <= cps_s22;
			sth_s23 <= sth_s22;

			// third factor: (a*b)*c
			t1_s24  <= ss_s23 * cps_s23;
			t2_s24  <= cs_s23 * cps_s23;
			t3_s24  <= ss_s23 * sps_s23;
			t4_s24  <= cs_s23 * sps_s23;
			p0_s24  <= p0_s23;
			p3_s24  <= p3_s23;
			p7_s24  <= p7_s23;
			p8_s24  <= p8_s23;
			p1_s24  <= p1_s23;
			p2_s24  <= p2_s23;
			p4_s24  <= p4_s23;
			p5_s24  <= p5_s23;
			sth_s24 <= sth_s23;

			t1_s25  <= 32'(eul_pkg::rnd_shift(t1_s24, 30));
			t2_s25  <= 32'(eul_pkg::rnd_shift(t2_s24, 30));
			t3_s25  <= 32'(eul_pkg::rnd_shift(t3_s24, 30));
			t4_s25  <= 32'(eul_pkg::rnd_shift(t4_s24, 30));
			p0_s25  <= p0_s24;
			p3_s25  <= p3_s24;
			p7_s25  <= p7_s24;
			p8_s25  <= p8_s24;
			p1_s25  <= p1_s24;
			p2_s25  <= p2_s24;
			p4_s25  <= p4_s24;
			p5_s25  <= p5_s24;
			sth_s25 <= sth_s24;

			// two-term entries summed in Q30
			m_s26[0] <= 33'(p0_s25);
			m_s26[1] <= 33'(t1_s25) - 33'(p1_s25);
			m_s26[2] <= 33'(t2_s25) + 33'(p2_s25);
			m_s26[3] <= 33'(p3_s25);
			m_s26[4] <= 33'(t3_s25) + 33'(p4_s25);
			m_s26[5] <= 33'(t4_s25) - 33'(p5_s25);
			m_s26[6] <= -33'(sth_s25);
			m_s26[7] <= 33'(p7_s25);
			m_s26[8] <= 33'(p8_s25);
		end
	end

	// order 1-2-3 takes the transpose; round and saturate to Q1.14
	for (genvar i = 0; i < 9; i++) begin : g_out
		localparam int TI = (i % 3) * 3 + i / 3;

		always_ff @(posedge clk) begin
			if (en) begin
				out_s27[i] <= eul_pkg::to_q14(ord_s[LAT-1] ? m_s26[TI] : m_s26[i]);
			end
		end

		assign m_tdata[16*i +: 16] = out_s27[i];
	end

	// a stalled pipe keeps its valid bits
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> $stable(m_tvalid) && $stable(vld_s[1]))
		else $error("valid bits moved during a stall");

	// an accepted beat enters the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_s[1])
		else $error("accepted beat lost at entry");

	// entries m13 and m31 stay within unit magnitude
	a_entry_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[47:32]) <= 16'sd16384)
			&& ($signed(m_tdata[47:32]) >= -16'sd16384)
			&& ($signed(m_tdata[111:96]) <= 16'sd16384)
			&& ($signed(m_tdata[111:96]) >= -16'sd16384))
		else $error("matrix entry beyond unit magnitude");

endmodule

`default_nettype wire

>>> bench/euler_to_rotation_matrix_top_tb.sv
`timescale 1ns / 1ps

module euler_to_rotation_matrix_top_tb;

	typedef struct packed {
		logic [15:0] yaw;
		logic [15:0] pitch;
		logic [15:0] roll;
		logic        order;
	} angle_beat_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [47:0]  s_tdata;
	logic [0:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [143:0] m_tdata;

	angle_beat_t  angle_q[$];      // beats waiting to be driven
	logic [143:0] matrix_q[$];     // matrices expected on the output
	int           err_cnt;
	bit           stim_done;
	int           n_items;         // beats queued for the run
	int           n_seen;          // matrix beats taken on the output

	euler_to_rotation_matrix_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// round to nearest, halves away from zero
	function automatic longint round_shift(longint p, int sh);
		longint half;
		half = longint'(1) << (sh - 1);
		if (p >= 0) begin
			return (p + half) >>> sh;
		end
		return -((-p + half) >>> sh);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return round_shift(a * b, 30);
	endfunction

	// sine and cosine in Q30 of a Q3.12 angle
	function automatic void trig_q30(logic signed [15:0] ang, output longint sn,
		output longint cs);
		longint one, hp, xp, k, r, r2, u, s, c;
		one = 64'sd1073741824;
		hp = 64'sd421657428;
		xp = longint'(ang) * 65536 + 8 * hp + 64'sd210828714;
		k = xp / hp;
		r = (xp - k * hp - 64'sd210828714) * 4;
		r2 = qmul(r, r);
		u = one - r2 / 42;
		u = one - qmul(r2, u) / 20;
		u = one - qmul(r2, u) / 6;
		s = qmul(r, u);
		u = one - r2 / 56;
		u = one - qmul(r2, u) / 30;
		u = one - qmul(r2, u) / 12;
		c = one - qmul(r2, u) / 2;
		case (k & 3)
			0: begin sn = s;  cs = c;  end
			1: begin sn = c;  cs = -s; end
			2: begin sn = -s; cs = -c; end
			default: begin sn = -c; cs = s; end
		endcase
	endfunction

	function automatic logic [15:0] sat_q14(longint v);
		longint e;
		e = round_shift(v, 16);
		if (e > 16384) begin
			e = 16384;
		end
		if (e < -16384) begin
			e = -16384;
		end
		return e[15:0];
	endfunction

	function automatic logic [143:0] rotation_matrix(angle_beat_t b);
		longint sph, cph, sth, cth, sps, cps;
		longint m[9];
		logic [143:0] packed_m;
		int src;
		trig_q30(b.roll, sph, cph);
		trig_q30(b.pitch, sth, cth);
		trig_q30(b.yaw, sps, cps);
		m[0] = qmul(cth, cps);
		m[1] = qmul(qmul(sph, sth), cps) - qmul(cph, sps);
		m[2] = qmul(qmul(cph, sth), cps) + qmul(sph, sps);
		m[3] = qmul(cth, sps);
		m[4] = qmul(qmul(sph, sth), sps) + qmul(cph, cps);
		m[5] = qmul(qmul(cph, sth), sps) - qmul(sph, cps);
		m[6] = -sth;
		m[7] = qmul(sph, cth);
		m[8] = qmul(cph, cth);
		// 1-2-3 is the transpose of 3-2-1
		for (int i = 0; i < 9; i++) begin
			src = b.order ? ((i % 3) * 3 + i / 3) : i;
			packed_m[i*16 +: 16] = sat_q14(m[src]);
		end
		return packed_m;
	endfunction

	// mostly short gaps, now and then a long one, often none
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) begin
			return 0;
		end
		if (p < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] rand_angle();
		case ($urandom_range(0, 5))
			0: return 16'h8000 + 16'($urandom_range(0, 3));
			1: return 16'h7fff - 16'($urandom_range(0, 3));
			2: return 16'($signed($urandom_range(0, 6434)) - 3217); // within +-pi/4
			default: return 16'($urandom);
		endcase
	endfunction

	// driver: pull beats from the queue, hold valid through backpressure
	int src_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			src_gap = 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				matrix_q = {matrix_q, rotation_matrix({s_tdata, s_tuser[0]})};
			end
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (angle_q.size() > 0) begin
				angle_beat_t b;
				b = angle_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {b.yaw, b.pitch, b.roll};
				s_tuser <= b.order;
				src_gap = gap_len();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: check each matrix beat, drive random backpressure
	int sink_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_seen++;
				if (matrix_q.size() == 0) begin
					$error("unexpected matrix beat %h", m_tdata);
					err_cnt++;
				end else begin
					logic [143:0] exp_m;
					exp_m = matrix_q.pop_front();
					for (int i = 0; i < 9; i++) begin
						if (exp_m[i*16 +: 16] !== m_tdata[i*16 +: 16]) begin
							$error("m%0d%0d: expected %0d actual %0d", i / 3 + 1, i % 3 + 1,
								$signed(exp_m[i*16 +: 16]), $signed(m_tdata[i*16 +: 16]));
							err_cnt++;
						end
					end
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				sink_gap = gap_len();
			end
		end
	end

	initial begin
		angle_beat_t b;
		logic [15:0] corner[6];
		err_cnt = 0;
		n_seen = 0;
		stim_done = 0;
		arst_n = 1'b0;
		corner = '{16'h0000, 16'h8000, 16'h7fff, 16'h1922, 16'he6de, 16'h3244};
		// directed: angle extremes, both orders, angles near +-pi/2 and pi
		for (int i = 0; i < 6; i++) begin
			for (int o = 0; o < 2; o++) begin
				b.roll = corner[i];
				b.pitch = corner[(i + 1) % 6];
				b.yaw = corner[(i + 2) % 6];
				b.order = o[0];
				angle_q = {angle_q, b};
			end
		end
		b.yaw = 16'hffff;
		b.pitch = 16'hffff;
		b.roll = 16'hffff;
		b.order = 1'b1;
		angle_q = {angle_q, b};
		b.yaw = 16'h8000;
		b.pitch = 16'h8000;
		b.roll = 16'h8000;
		b.order = 1'b0;
		angle_q = {angle_q, b};
		b.yaw = 16'h7fff;
		b.pitch = 16'h7fff;
		b.roll = 16'h7fff;
		b.order = 1'b1;
		angle_q = {angle_q, b};
		for (int i = 0; i < 1850; i++) begin
			b.roll = rand_angle();
			b.pitch = rand_angle();
			b.yaw = rand_angle();
			b.order = 1'($urandom);
			angle_q = {angle_q, b};
		end
		n_items = angle_q.size();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// every queued beat must come back; extra beats show up as unexpected
		wait (n_seen >= n_items);
		stim_done = 1;
		repeat (eul_pkg::LAT + 10) @(posedge clk);
		if (matrix_q.size() != 0) begin
			$error("%0d matrix beats never arrived", matrix_q.size());
			err_cnt++;
		end
		if (err_cnt == 0) begin
			$display("euler_to_rotation_matrix_top_tb: clean");
		end else begin
			$display("euler_to_rotation_matrix_top_tb: errors");
		end
		$finish;
	end

	// give up well beyond the slowest legitimate run
	initial begin
		#5ms;
		$display("euler_to_rotation_matrix_top_tb: errors");
		$finish;
	end

endmodule
